// File: rtl/core/fifo_page_replacement_top_assert.svh
// Assertion macros used by the page replacement controller RTL.
`ifndef FIFO_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FPR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("page replacement check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FPR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("page replacement check failed");

`endif

// File: rtl/core/fpr_pkg.sv
package fpr_pkg;

  localparam int CNT_W = 4;
  localparam int OUT_PAGE_W = 16;
  localparam int IN_TDATA_W = 16;
  localparam int RES_W = 85;
  localparam int OUT_TDATA_W = 88;
  localparam logic [CNT_W-1:0] FRAME_COUNT_RESET = 4'd3;
  localparam logic [0:0] REG_FRAME_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic             clear;
    logic [CNT_W-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic [31:0]           hit_total;
    logic [31:0]           fault_total;
    logic [2:0]            slot_written;
    logic [OUT_PAGE_W-1:0] evicted_page;
    logic                  evicted_valid;
    logic                  hit;
  } res_t;

endpackage

// File: rtl/core/fifo_page_replacement_top.sv
// Each word is accepted in ST_IDLE, searched in ST_SCAN and loaded into the output register from ST_DONE.
// One word is searched at a time; the search reads the frame memory one entry a cycle.
// The next word is taken while a finished result still waits on the output register.
// Reset (rst, synchronous, active high) empties all frames, clears both counts and sets
// frame_count to 3; the frame memory needs no clearing pass.
module fifo_page_replacement_top #(
  parameter int FRAMES = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] page_number
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] hit, [1] evicted_valid, [17:2] evicted_page, [20:18] slot_written,
  // [52:21] fault_total, [84:53] hit_total, [87:85] zero
  output logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [fpr_pkg::CNT_W-1:0] frame_count;
  logic cfg_we;
  fpr_pkg::cfg_t cfg;
  fpr_pkg::res_t res;
  logic [PAGE_BITS+fpr_pkg::IN_TDATA_W-1:0] page_ext;
  logic mem_we;
  logic [SW-1:0] mem_waddr;
  logic [SW-1:0] mem_raddr;
  logic [PAGE_BITS-1:0] mem_wdata;
  logic [PAGE_BITS-1:0] mem_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == fpr_pkg::REG_FRAME_COUNT);
  assign prdata = (paddr[2] == fpr_pkg::REG_FRAME_COUNT) ? {28'd0, frame_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= fpr_pkg::FRAME_COUNT_RESET;
    end else if (cfg_we) begin
      frame_count <= pwdata[fpr_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    cfg.clear = cfg_we;
    if (frame_count == '0) begin
      cfg.cap = 4'd1;
    end else if ({28'd0, frame_count} > 32'(FRAMES)) begin
      cfg.cap = 4'(FRAMES);
    end else begin
      cfg.cap = frame_count;
    end
  end

  assign page_ext = {{PAGE_BITS{1'b0}}, s_tdata};
  assign m_tdata = {3'b000, res};

  fpr_ctrl #(
    .FRAMES(FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .s_valid(s_tvalid),
    .s_ready(s_tready),
    .s_page(page_ext[PAGE_BITS-1:0]),
    .m_valid(m_tvalid),
    .m_ready(m_tready),
    .m_res(res),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  fpr_frame_mem #(
    .DEPTH(FRAMES),
    .WIDTH(PAGE_BITS)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule

// File: rtl/core/fpr_frame_mem.sv
module fpr_frame_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fpr_ctrl.sv
`include "fifo_page_replacement_top_assert.svh"

module fpr_ctrl #(
  parameter int FRAMES = 8,
  parameter int PAGE_BITS = 16,
  localparam int SW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fpr_pkg::cfg_t        cfg,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  logic [PAGE_BITS-1:0] s_page,
  output logic                 m_valid,
  input  logic                 m_ready,
  output fpr_pkg::res_t        m_res,
  output logic                 mem_we,
  output logic [SW-1:0]        mem_waddr,
  output logic [PAGE_BITS-1:0] mem_wdata,
  output logic [SW-1:0]        mem_raddr,
  input  logic [PAGE_BITS-1:0] mem_rdata
);

  function automatic logic [SW-1:0] to_addr(input logic [fpr_pkg::CNT_W-1:0] v);
    logic [SW+fpr_pkg::CNT_W-1:0] e;
    e = {{SW{1'b0}}, v};
    return e[SW-1:0];
  endfunction

  fpr_pkg::state_t state;
  logic [PAGE_BITS-1:0] page;
  logic [PAGE_BITS-1:0] victim;
  logic [fpr_pkg::CNT_W-1:0] idx;
  logic [fpr_pkg::CNT_W-1:0] rd_slot;
  logic rd_pend;
  logic found;
  logic [fpr_pkg::CNT_W-1:0] resident;
  logic [fpr_pkg::CNT_W-1:0] oldest_slot;
  logic [31:0] fault_counter;
  logic [31:0] hit_counter;

  logic full;
  logic load;
  logic [fpr_pkg::CNT_W-1:0] slot;
  logic [fpr_pkg::CNT_W-1:0] slot_inc;
  logic [31:0] fault_next;
  logic [31:0] hit_next;
  logic [PAGE_BITS+fpr_pkg::OUT_PAGE_W-1:0] victim_ext;
  fpr_pkg::res_t res_next;

  assign s_ready = (state == fpr_pkg::ST_IDLE);
  assign full = (resident >= cfg.cap);
  assign slot = full ? oldest_slot : resident;
  assign slot_inc = slot + 1'b1;
  assign load = (state == fpr_pkg::ST_DONE) && (!m_valid || m_ready);
  assign fault_next = (fault_counter == '1) ? fault_counter : fault_counter + 32'd1;
  assign hit_next = (hit_counter == '1) ? hit_counter : hit_counter + 32'd1;
  assign victim_ext = {{fpr_pkg::OUT_PAGE_W{1'b0}}, victim};

  assign mem_raddr = to_addr(idx);
  assign mem_we = load && !found;
  assign mem_waddr = to_addr(slot);
  assign mem_wdata = page;

  always_comb begin
    res_next.hit = found;
    res_next.evicted_valid = !found && full;
    res_next.evicted_page = (!found && full) ? victim_ext[fpr_pkg::OUT_PAGE_W-1:0] : '0;
    res_next.slot_written = found ? 3'd0 : slot[2:0];
    res_next.fault_total = found ? fault_counter : fault_next;
    res_next.hit_total = found ? hit_next : hit_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpr_pkg::ST_IDLE;
      rd_pend <= 1'b0;
      found <= 1'b0;
      idx <= '0;
      resident <= '0;
      oldest_slot <= '0;
      fault_counter <= '0;
      hit_counter <= '0;
      m_valid <= 1'b0;
    end else begin
      if (load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
      if (cfg.clear) begin
        resident <= '0;
        oldest_slot <= '0;
      end
      unique case (state)
        fpr_pkg::ST_IDLE: begin
          if (s_valid) begin
            state <= fpr_pkg::ST_SCAN;
            idx <= '0;
            rd_pend <= 1'b0;
            found <= 1'b0;
          end
        end
        fpr_pkg::ST_SCAN: begin
          if (rd_pend && (mem_rdata == page)) begin
            found <= 1'b1;
          end
          if (idx < resident) begin
            rd_pend <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            state <= fpr_pkg::ST_DONE;
          end
        end
        fpr_pkg::ST_DONE: begin
          if (load) begin
            state <= fpr_pkg::ST_IDLE;
            if (found) begin
              hit_counter <= hit_next;
            end else begin
              fault_counter <= fault_next;
              if (full) begin
                oldest_slot <= (slot_inc == cfg.cap) ? '0 : slot_inc;
              end else begin
                resident <= resident + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= fpr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      page <= s_page;
    end
    if (state == fpr_pkg::ST_SCAN) begin
      rd_slot <= idx;
      if (rd_pend && (rd_slot == oldest_slot)) begin
        victim <= mem_rdata;
      end
    end
    if (load) begin
      m_res <= res_next;
    end
  end

  `FPR_ASSERT_IMP(a_resident_le_cap, clk, rst, 1'b1, resident <= cfg.cap)
  `FPR_ASSERT_IMP(a_oldest_in_range, clk, rst, 1'b1, (oldest_slot < cfg.cap) || (oldest_slot == '0))
  `FPR_ASSERT_NXT(a_accept_starts_scan, clk, rst, s_valid && s_ready, state == fpr_pkg::ST_SCAN)
  `FPR_ASSERT_IMP(a_hit_no_fill, clk, rst, m_valid && m_res.hit, !m_res.evicted_valid && (m_res.slot_written == 3'd0))

endmodule

// File: sim/fpr_result_check.sv
`timescale 1ns / 100ps

module fpr_result_check #(
  parameter int FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending,
  output int          words_checked,
  output int          hits_seen
);

  logic [15:0]   frame_pg [FRAMES];
  bit            frame_vld [FRAMES];
  int unsigned   oldest;
  int unsigned   resident;
  logic [31:0]   fault_cnt;
  logic [31:0]   hit_cnt;
  logic [3:0]    frames_used;
  fpr_pkg::res_t pending_lookups [$];

  int mismatch_cnt = 0;
  int checked_cnt = 0;
  int hit_cnt_seen = 0;
  int queued = 0;

  assign mismatches = mismatch_cnt;
  assign pending = queued;
  assign words_checked = checked_cnt;
  assign hits_seen = hit_cnt_seen;

  task automatic empty_frames();
    for (int i = 0; i < FRAMES; i++) begin
      frame_pg[i] = '0;
      frame_vld[i] = 1'b0;
    end
    oldest = 0;
    resident = 0;
  endtask

  function automatic fpr_pkg::res_t lookup_page(logic [15:0] pg);
    fpr_pkg::res_t r;
    int unsigned   cap;
    int unsigned   slot;
    bit            found;
    r = '0;
    found = 1'b0;
    slot = 0;
    cap = (frames_used == 0) ? 1 : (frames_used > FRAMES) ? FRAMES : frames_used;
    for (int i = 0; i < FRAMES; i++) begin
      if (frame_vld[i] && frame_pg[i] == pg) found = 1'b1;
    end
    if (found) begin
      if (hit_cnt != '1) hit_cnt++;
      r.hit = 1'b1;
    end else begin
      if (resident >= cap) begin
        slot = oldest % cap;
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_pg[slot];
        oldest = (slot + 1) % cap;
      end else begin
        slot = resident;
        resident++;
      end
      frame_pg[slot] = pg;
      frame_vld[slot] = 1'b1;
      if (fault_cnt != '1) fault_cnt++;
      r.slot_written = slot[2:0];
    end
    r.fault_total = fault_cnt;
    r.hit_total = hit_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    fpr_pkg::res_t want;
    fpr_pkg::res_t got;
    if (rst) begin
      empty_frames();
      fault_cnt = '0;
      hit_cnt = '0;
      frames_used = fpr_pkg::FRAME_COUNT_RESET;
      pending_lookups.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        checked_cnt++;
        got = fpr_pkg::res_t'(m_tdata[fpr_pkg::RES_W-1:0]);
        if (got.hit) hit_cnt_seen++;
        if (pending_lookups.size() == 0) begin
          $display("%0t: unexpected result word %0h", $time, m_tdata);
          mismatch_cnt++;
        end else begin
          want = pending_lookups.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
          check_field("slot_written", 32'(want.slot_written), 32'(got.slot_written));
          check_field("fault_total", want.fault_total, got.fault_total);
          check_field("hit_total", want.hit_total, got.hit_total);
          check_field("pad bits", 32'd0,
                      32'(m_tdata[fpr_pkg::OUT_TDATA_W-1:fpr_pkg::RES_W]));
        end
      end
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
          && paddr[2] == fpr_pkg::REG_FRAME_COUNT) begin
        frames_used = pwdata[fpr_pkg::CNT_W-1:0];
        empty_frames();
      end
      if (s_tvalid && s_tready) pending_lookups.push_back(lookup_page(s_tdata));
    end
    queued = pending_lookups.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int TOTAL_ITEMS = 1850;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam logic [2:0] FRAME_COUNT_ADDR = {fpr_pkg::REG_FRAME_COUNT, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = {~fpr_pkg::REG_FRAME_COUNT, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int words_checked;
  int hits_seen;

  int          items_sent = 0;
  int          settings_used = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b0;
  bit          hold_rx = 1'b0;
  int          idle_cycles = 0;
  logic [15:0] work_set [16];
  int          work_n = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_page_replacement_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  fpr_result_check result_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .pending(pending),
    .words_checked(words_checked), .hits_seen(hits_seen)
  );

  task automatic send_page(input logic [15:0] pg);
    s_tvalid <= 1'b1;
    s_tdata <= pg;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == FRAME_COUNT_ADDR) settings_used++;
  endtask

  function automatic logic [15:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return work_set[$urandom_range(0, work_n - 1)];
    if (r < 90) return 16'($urandom);
    if (r < 95) return 16'h0000;
    return 16'hffff;
  endfunction

  // The receiver switches between steady, random and stalled patterns, and
  // honors a request for one long hold-off.
  initial begin : rx_side
    int mode;
    int run;
    mode = 0;
    run = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (run == 0) begin
        mode = $urandom_range(0, 3);
        run = (mode == 3) ? $urandom_range(5, 30) : $urandom_range(20, 120);
      end
      run--;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int          plan [8];
    int          phase;
    int          n_items;
    int          cap;
    logic [31:0] data;
    plan = '{1, 8, 0, 15, 9, 2, 5, 8};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Three frames out of reset: fill, hit, then wrap the oldest pointer.
    send_page(16'h0000);
    send_page(16'hffff);
    send_page(16'h0000);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0000);
    send_page(16'hffff);
    send_page(16'h0001);
    drain();

    // A frame count of zero behaves as one frame.
    reg_write(FRAME_COUNT_ADDR, 32'hffff_fff0);
    send_page(16'h0005);
    send_page(16'h0005);
    send_page(16'h0006);
    send_page(16'h0005);
    drain();

    // A write to an unused register must leave the frames alone.
    reg_write(UNUSED_ADDR, 32'h0000_0007);
    send_page(16'h0005);
    drain();

    // A frame count above the built size is clamped to it.
    reg_write(FRAME_COUNT_ADDR, 32'h0000_000f);
    for (int i = 0; i < 9; i++) send_page(16'(1 << i));
    send_page(16'h0002);
    drain();

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      data = $urandom;
      data[3:0] = 4'((phase < 8) ? plan[phase] : $urandom_range(0, 15));
      reg_write(FRAME_COUNT_ADDR, data);
      cap = (data[3:0] == 0) ? 1 : (data[3:0] > 8) ? 8 : data[3:0];
      work_n = $urandom_range(1, cap + 3);
      for (int i = 0; i < 16; i++) work_set[i] = 16'($urandom);
      gaps_on = ($urandom_range(0, 9) < 7);
      burst_left = $urandom_range(1, 20);
      if (phase == 2) begin
        gaps_on = 1'b0;
        hold_rx = 1'b1;
      end
      n_items = $urandom_range(100, 200);
      for (int i = 0; i < n_items && items_sent < TOTAL_ITEMS; i++) send_page(pick_page());
      drain();
      phase++;
    end

    $display("Sent %0d page references over %0d frame count settings.",
             items_sent, settings_used);
    $display("Checked %0d result words, %0d hits among them.", words_checked, hits_seen);
    if (pending != 0) $display("%0d expected result words never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/fpr_pkg.sv
rtl/core/fpr_frame_mem.sv
rtl/core/fpr_ctrl.sv
rtl/core/fifo_page_replacement_top.sv
sim/fpr_result_check.sv
sim/tb_top.sv
